[rtl/cbpc_pkg.sv]
// ----------------------------------------------------------------------------
// cbpc_pkg: shared constants and types
// Widths and the control state type for the contour measurement block.
// ----------------------------------------------------------------------------
`default_nettype none
package cbpc_pkg;
  localparam int MAX_POINTS = 4096;
  localparam int COORD_W    = 24;
  localparam int COUNT_W    = 13;
  localparam int SUM_W      = 36;
  localparam int LEN_W      = 40;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQ_CNT_W   = $clog2(ROOT_W);
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_SQRT,
    ST_ACC,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } cbpc_state_t;
endpackage
`default_nettype wire

[rtl/contour_bbox_perimeter_centroid.sv]
// ----------------------------------------------------------------------------
// contour_bbox_perimeter_centroid
// Bounding box, open perimeter, box center and mean point of a contour.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_x, in_y, in_last
// out     | output    | out_valid, out_ready, out_min_x .. out_overflow
//
// A point with no segment is taken in IDLE; a segment then passes MUL, LOAD,
// the two-bit-per-cycle square root unit (SQRT) and ACC.
// A last point then adds a setup state (PREP), the bit-serial mean
// dividers (DIV) and FIN, which loads the output register.
// Reset (synchronous, rst_n low) clears all accumulators and out_valid.
// A result waits in the output register; a new transaction is accepted
// while it waits, and only the next result stalls behind it.
// ----------------------------------------------------------------------------
`default_nettype none
module contour_bbox_perimeter_centroid (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [cbpc_pkg::COORD_W-1:0] in_x,
  input  wire logic signed [cbpc_pkg::COORD_W-1:0] in_y,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_min_x,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_max_x,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_min_y,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_max_y,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_center_x,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_center_y,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_mean_x,
  output logic signed [cbpc_pkg::COORD_W-1:0]     out_mean_y,
  output logic [cbpc_pkg::LEN_W-1:0]              out_perimeter,
  output logic [cbpc_pkg::COUNT_W-1:0]            out_point_count,
  output logic                                    out_overflow
);
  import cbpc_pkg::*;

  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [COUNT_W-1:0] CNT_LIM = COUNT_W'(MAX_POINTS);

  cbpc_state_t state_r, state_nxt;

  // accumulators
  logic signed [COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic                      have_prev_r;
  logic [LEN_W-1:0]          len_r;
  logic [COUNT_W-1:0]        cnt_r;
  logic                      ovf_r;
  logic                      last_r;

  // segment datapath
  logic [DIFF_W-1:0] adx_r, ady_r;
  logic [SQ_W-1:0]   sqx_r, sqy_r, v_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [SQ_CNT_W-1:0] sq_cnt_r;

  // divider datapath (x and y lanes)
  logic [SUM_W-1:0]   nx_r, ny_r;
  logic [COUNT_W-1:0] rx_r, ry_r;
  logic               negx_r, negy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic accept, seg_go, take;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [REM_W-1:0] rem_sh, trial;
  logic [COUNT_W:0] dxs, dys;
  logic [LEN_W:0]   len_sum;
  logic signed [COORD_W:0] csx, csy;
  logic [COORD_W-1:0] qx, qy;

  assign accept = in_valid && in_ready;
  assign seg_go = (cnt_r < CNT_LIM) && have_prev_r;
  assign take   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) begin
        if (seg_go)       state_nxt = ST_MUL;
        else if (in_last) state_nxt = ST_PREP;
      end
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SQRT;
      ST_SQRT: if (sq_cnt_r == SQ_CNT_W'(ROOT_W-1)) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_PREP : ST_IDLE;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == DIV_CNT_W'(SUM_W-1)) state_nxt = ST_FIN;
      ST_FIN:  if (take) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready = (state_r == ST_IDLE);
  end

  // combinational helpers
  always_comb begin
    dx      = DIFF_W'(in_x) - DIFF_W'(prev_x_r);
    dy      = DIFF_W'(in_y) - DIFF_W'(prev_y_r);
    rem_sh  = {rem_r[REM_W-3:0], v_r[SQ_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    dxs     = {rx_r, nx_r[SUM_W-1]} - {1'b0, cnt_r};
    dys     = {ry_r, ny_r[SUM_W-1]} - {1'b0, cnt_r};
    len_sum = {1'b0, len_r} + (LEN_W+1)'(root_r);
    csx     = (COORD_W+1)'(max_x_r) + (COORD_W+1)'(min_x_r);
    csy     = (COORD_W+1)'(max_y_r) + (COORD_W+1)'(min_y_r);
    qx      = negx_r ? COORD_W'(-nx_r[COORD_W-1:0]) : nx_r[COORD_W-1:0];
    qy      = negy_r ? COORD_W'(-ny_r[COORD_W-1:0]) : ny_r[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == ST_FIN && take)) begin
      min_x_r <= CMAX; min_y_r <= CMAX;
      max_x_r <= CMIN; max_y_r <= CMIN;
      sum_x_r <= '0; sum_y_r <= '0;
      prev_x_r <= '0; prev_y_r <= '0;
      have_prev_r <= 1'b0;
      len_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      last_r <= 1'b0;
    end else if (accept) begin
      last_r <= in_last;
      if (cnt_r < CNT_LIM) begin
        if (in_x < min_x_r) min_x_r <= in_x;
        if (in_x > max_x_r) max_x_r <= in_x;
        if (in_y < min_y_r) min_y_r <= in_y;
        if (in_y > max_y_r) max_y_r <= in_y;
        sum_x_r <= sum_x_r + SUM_W'(in_x);
        sum_y_r <= sum_y_r + SUM_W'(in_y);
        prev_x_r <= in_x;
        prev_y_r <= in_y;
        have_prev_r <= 1'b1;
        cnt_r <= cnt_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (state_r == ST_ACC) begin
      len_r <= len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];
    end
  end

  // segment length: abs diff, square, then two-bit-per-cycle root
  always_ff @(posedge clk) begin
    if (accept) begin
      adx_r <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      ady_r <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    end
    if (state_r == ST_MUL) begin
      sqx_r <= adx_r * adx_r;
      sqy_r <= ady_r * ady_r;
    end
    if (state_r == ST_LOAD) begin
      v_r      <= sqx_r + sqy_r;
      rem_r    <= '0;
      root_r   <= '0;
      sq_cnt_r <= '0;
    end else if (state_r == ST_SQRT) begin
      v_r      <= {v_r[SQ_W-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 1'b1;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // mean: bit-serial restoring division of |sum| by count
  always_ff @(posedge clk) begin
    // setup cycle: sums already hold the last point
    if (state_r == ST_PREP) begin
      negx_r <= sum_x_r[SUM_W-1];
      negy_r <= sum_y_r[SUM_W-1];
      nx_r   <= sum_x_r[SUM_W-1] ? SUM_W'(-sum_x_r) : SUM_W'(sum_x_r);
      ny_r   <= sum_y_r[SUM_W-1] ? SUM_W'(-sum_y_r) : SUM_W'(sum_y_r);
      rx_r   <= '0;
      ry_r   <= '0;
      div_cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!dxs[COUNT_W]) begin
        rx_r <= dxs[COUNT_W-1:0];
        nx_r <= {nx_r[SUM_W-2:0], 1'b1};
      end else begin
        rx_r <= {rx_r[COUNT_W-2:0], nx_r[SUM_W-1]};
        nx_r <= {nx_r[SUM_W-2:0], 1'b0};
      end
      if (!dys[COUNT_W]) begin
        ry_r <= dys[COUNT_W-1:0];
        ny_r <= {ny_r[SUM_W-2:0], 1'b1};
      end else begin
        ry_r <= {ry_r[COUNT_W-2:0], ny_r[SUM_W-1]};
        ny_r <= {ny_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_FIN && take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && take) begin
      out_min_x       <= min_x_r;
      out_max_x       <= max_x_r;
      out_min_y       <= min_y_r;
      out_max_y       <= max_y_r;
      out_center_x    <= csx[COORD_W:1];
      out_center_y    <= csy[COORD_W:1];
      out_mean_x      <= qx;
      out_mean_y      <= qy;
      out_perimeter   <= len_r;
      out_point_count <= cnt_r;
      out_overflow    <= ovf_r;
    end
  end
endmodule
`default_nettype wire
